// File: design/nmu_pkg.sv
// nmu_pkg: shared types, constants and saturation helper for the
// nesterov momentum update block; no dependencies
package nmu_pkg;

	// number formats
	localparam int VALUE_BITS = 32;
	localparam int RATE_BITS  = 16;
	localparam int FRAC_BITS  = 16;
	localparam int INDEX_BITS = 10;
	localparam int COUNT_BITS = 11;
	localparam int SUM_BITS   = VALUE_BITS + 2;
	localparam int PROD_BITS  = VALUE_BITS + RATE_BITS + 1;

	// operation codes
	localparam logic [1:0] OP_LOOKAHEAD = 2'd0;
	localparam logic [1:0] OP_GRADIENT  = 2'd1;
	localparam logic [1:0] OP_CLEAR     = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_MOMENTUM      = 2'd0;
	localparam logic [1:0] REG_LEARNING_RATE = 2'd1;
	localparam logic [1:0] REG_ACTIVE_COUNT  = 2'd2;

	localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	typedef struct packed {
		logic [1:0]                   op;
		logic [INDEX_BITS-1:0]        index;
		logic signed [VALUE_BITS-1:0] param_value;
		logic signed [VALUE_BITS-1:0] gradient;
	} in_word_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] new_param;
		logic signed [VALUE_BITS-1:0] new_velocity;
		logic                         index_error;
		logic                         saturated;
	} out_word_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  hit;
	} sat_t;

	// clamp a widened sum to the signed value range
	function automatic sat_t sat_value(input logic [SUM_BITS-1:0] s);
		sat_t r;
		if (s[SUM_BITS-1:VALUE_BITS-1] == '0 || s[SUM_BITS-1:VALUE_BITS-1] == '1) begin
			r.value = s[VALUE_BITS-1:0];
			r.hit   = 1'b0;
		end else begin
			r.value = s[SUM_BITS-1] ? VAL_MIN : VAL_MAX;
			r.hit   = 1'b1;
		end
		return r;
	endfunction

endpackage

// File: design/nmu_vel_store.sv
// nmu_vel_store: velocity memory with a zeroing sweep after reset and
// bypass of a write landing on the same edge as a read; uses nmu_pkg
module nmu_vel_store import nmu_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output logic [VALUE_BITS-1:0] rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [VALUE_BITS-1:0] wr_data,
	output logic                  busy
);

	logic [VALUE_BITS-1:0] mem [DEPTH];
	logic [VALUE_BITS-1:0] rd_q;
	logic [VALUE_BITS-1:0] fwd_q;
	logic                  hit_q;
	logic                  busy_q;
	logic [AW-1:0]         clr_cnt_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_wa;
	logic [VALUE_BITS-1:0] mem_wd;

	// sweep takes the write port until every entry is zero
	always_comb begin
		mem_we = busy_q | wr_en;
		mem_wa = busy_q ? clr_cnt_q : wr_addr;
		mem_wd = busy_q ? '0 : wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_cnt_q <= '0;
		end else if (busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// memory array, read data registered
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_q  <= mem[rd_addr];
			fwd_q <= wr_data;
		end
	end

	// same-edge write to the address being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (rd_en) begin
			hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = hit_q ? fwd_q : rd_q;
	assign busy    = busy_q;

endmodule

// File: design/nesterov_momentum_update.sv
// nesterov_momentum_update: top level, configuration registers, update
// datapath and result register; uses nmu_pkg and nmu_vel_store
//
// Usage:
//   in_valid/in_ready carry one input word (op, index, param, gradient);
//   out_valid/out_ready carry one result word per input word, in order.
//   cfg_write with cfg_index/cfg_data writes momentum, learning rate or
//   active count; write only while no word is in flight.
// Path: an accepted word is registered in the compute stage (word_s1),
//   then moves to the result register (out_q) once that register is free.
// Throughput: one word per cycle when not stalled; the velocity memory is
//   read at accept and written back as the word moves to the result register,
//   with a bypass so back-to-back words on the same index see the fresh value.
// Reset: the velocity memory is zeroed by a sweep over all MAX_PARAMS entries,
//   one entry per cycle; in_ready stays low until it ends, while
//   configuration writes are taken as usual.
// Stall: a held result keeps the compute stage full; after the sweep, in_ready
//   drops only while both stages are occupied and the result is not taken.
//
module nesterov_momentum_update import nmu_pkg::*; #(
	parameter int MAX_PARAMS = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  in_word_t       in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output out_word_t      out_data,
	input  logic           cfg_write,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data
);

	localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

	logic [RATE_BITS-1:0]  momentum_q;
	logic [RATE_BITS-1:0]  learning_rate_q;
	logic [COUNT_BITS-1:0] active_count_q;

	logic                  s1_valid_q;
	in_word_t              word_s1;
	logic                  out_valid_q;
	out_word_t             out_q;

	logic                  accept;
	logic                  s1_go;
	logic                  busy;
	logic [VALUE_BITS-1:0] vel;
	logic                  index_err;
	logic [RATE_BITS-1:0]  rate;
	logic signed [VALUE_BITS-1:0] opnd;
	logic signed [PROD_BITS-1:0]  prod;
	logic [SUM_BITS-1:0]   m_ext;
	logic [SUM_BITS-1:0]   p_ext;
	logic [SUM_BITS-1:0]   v_ext;
	logic [SUM_BITS-1:0]   np_sum;
	logic [SUM_BITS-1:0]   nv_sum;
	sat_t                  np_sat;
	sat_t                  nv_sat;
	out_word_t             result;
	logic                  wr_en;
	logic [VALUE_BITS-1:0] wr_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			momentum_q      <= RATE_BITS'(655);
			learning_rate_q <= '0;
			active_count_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MOMENTUM:      momentum_q      <= cfg_data[RATE_BITS-1:0];
				REG_LEARNING_RATE: learning_rate_q <= cfg_data[RATE_BITS-1:0];
				REG_ACTIVE_COUNT:  active_count_q  <= cfg_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign s1_go    = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !busy && (!s1_valid_q || s1_go);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= in_data;
		end
	end

	nmu_vel_store #(
		.DEPTH (MAX_PARAMS),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (AW'(in_data.index)),
		.rd_data (vel),
		.wr_en   (wr_en),
		.wr_addr (AW'(word_s1.index)),
		.wr_data (wr_data),
		.busy    (busy)
	);

	// index check against active count and store depth
	assign index_err = (COUNT_BITS'(word_s1.index) >= active_count_q) ||
		(32'(word_s1.index) >= 32'(MAX_PARAMS));

	// one shared multiply: velocity by momentum or gradient by rate
	always_comb begin
		if (word_s1.op == OP_LOOKAHEAD) begin
			opnd = $signed(vel);
			rate = momentum_q;
		end else begin
			opnd = word_s1.gradient;
			rate = learning_rate_q;
		end
		prod  = opnd * $signed({1'b0, rate});
		m_ext = SUM_BITS'($signed(prod[FRAC_BITS +: VALUE_BITS]));
		p_ext = SUM_BITS'(word_s1.param_value);
		v_ext = SUM_BITS'($signed(vel));
	end

	// saturating sums
	always_comb begin
		if (word_s1.op == OP_LOOKAHEAD) begin
			np_sum = p_ext + m_ext;
		end else begin
			np_sum = p_ext - m_ext;
		end
		nv_sum = v_ext - m_ext;
		np_sat = sat_value(np_sum);
		nv_sat = sat_value(nv_sum);
	end

	// result word and write-back
	always_comb begin
		result.new_param    = word_s1.param_value;
		result.new_velocity = '0;
		result.index_error  = 1'b0;
		result.saturated    = 1'b0;
		wr_data             = '0;
		wr_en               = 1'b0;
		if (index_err) begin
			result.index_error = 1'b1;
		end else begin
			case (word_s1.op)
				OP_LOOKAHEAD: begin
					result.new_param    = np_sat.value;
					result.new_velocity = m_ext[VALUE_BITS-1:0];
					result.saturated    = np_sat.hit;
					wr_data             = m_ext[VALUE_BITS-1:0];
					wr_en               = s1_go;
				end
				OP_GRADIENT: begin
					result.new_param    = np_sat.value;
					result.new_velocity = nv_sat.value;
					result.saturated    = np_sat.hit | nv_sat.hit;
					wr_data             = nv_sat.value;
					wr_en               = s1_go;
				end
				OP_CLEAR: begin
					wr_en = s1_go;
				end
				default: begin
					result.new_velocity = vel;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
